[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the deque checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ODQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, held off during reset
`define ODQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

[src/odq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odq_pkg
// Types and constants for the overwriting bounded deque.
// ----------------------------------------------------------------------------
package odq_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed field widths of the request, result and config write
  localparam int OP_W   = 2;
  localparam int CFG_W  = 7;
  localparam int FILL_W = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND     = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [DATA_WIDTH-1:0] push_data;
  } odq_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result_data;
    logic                  result_valid;
    logic [FILL_W-1:0]     fill_count;
  } odq_out_t;

endpackage

[src/overwriting_bounded_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_bounded_deque
// Ring-buffer deque with overwrite-on-full, one request per clock when not stalled.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall is low (push at front, append at
// back, pop from front) and returns one result per request, in order, through
// the RAM read and result registers. Index and count updates happen at the
// accepting edge; the front word is read from the entry RAM in the same edge
// and the result is registered once the output is free, so a stalled output
// holds the RAM read register and, through it, the input side. When full,
// push overwrites the front entry and append drops it; the displaced word is
// returned with result_valid set. Writing cfg_wdata sets the slot count
// (0 acts as 1, above the pool size acts as the pool size) and empties the
// deque; write it only while no request is in flight. The RAM has no reset.
module overwriting_bounded_deque (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  odq_pkg::odq_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output odq_pkg::odq_out_t       out_data,
  input  logic                    cfg_we,
  input  logic [odq_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = odq_pkg::IDX_W;
  localparam int CNT_W = odq_pkg::CNT_W;
  localparam int DW    = odq_pkg::DATA_WIDTH;

  // ring state
  logic [CNT_W-1:0] cap_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // read stage and result register
  logic              a_valid_r;
  logic              a_hit_r, hit_nxt;
  logic [CNT_W-1:0]  a_fill_r;
  logic              out_valid_r;
  odq_pkg::odq_out_t out_r;

  logic             in_accept;
  logic             out_free;
  logic             a_move;
  logic             full;
  logic             empty;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] back_inc;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [DW-1:0]    ram_rdata;
  logic [CNT_W-1:0] cap_clamped;

  assign out_free  = !out_valid_r || !out_stall;
  assign a_move    = a_valid_r && out_free;
  assign in_stall  = a_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign full  = (count_r >= cap_r);
  assign empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? IDX_W'(cap_r - CNT_W'(1)) : front_r - IDX_W'(1);
  assign front_inc = ((CNT_W'(front_r) + CNT_W'(1)) == cap_r) ? '0 : front_r + IDX_W'(1);
  assign back_inc  = ((CNT_W'(back_r) + CNT_W'(1)) == cap_r) ? '0 : back_r + IDX_W'(1);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    hit_nxt   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = back_r;
    case (in_data.operation)
      odq_pkg::OP_PUSH_FRONT: begin
        ram_we = 1'b1;
        if (full) begin
          // overwrite in place, old front word goes out
          hit_nxt   = 1'b1;
          ram_waddr = front_r;
        end else begin
          front_nxt = front_dec;
          ram_waddr = front_dec;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      odq_pkg::OP_APPEND: begin
        ram_we   = 1'b1;
        back_nxt = back_inc;
        if (full) begin
          hit_nxt   = 1'b1;
          front_nxt = front_inc;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      odq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          hit_nxt   = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cfg_wdata == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (CNT_W'(cfg_wdata) > CNT_W'(odq_pkg::CAPACITY)
                 || (odq_pkg::CFG_W > CNT_W && (cfg_wdata >> CNT_W) != '0)) begin
      cap_clamped = CNT_W'(odq_pkg::CAPACITY);
    end else begin
      cap_clamped = CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CNT_W'(odq_pkg::CAPACITY);
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      cap_r   <= cap_clamped;
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (in_accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  odq_ram #(
    .WIDTH (DW),
    .DEPTH (odq_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (in_accept && ram_we && !cfg_we),
    .waddr (ram_waddr),
    .wdata (in_data.push_data),
    .re    (in_accept),
    .raddr (front_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_hit_r  <= hit_nxt;
      a_fill_r <= count_nxt;
    end
    if (a_move) begin
      out_r.result_data  <= a_hit_r ? ram_rdata : '0;
      out_r.result_valid <= a_hit_r;
      out_r.fill_count   <= odq_pkg::FILL_W'(a_fill_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/odq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// Read-first: a read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module odq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/odq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odq_checker
// Port-level checks for the overwriting bounded deque, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module odq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input odq_pkg::odq_out_t         out_data
);

  // a stalled result stays put
  `ODQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_data))

  // no word carried means a zero word
  `ODQ_ASSERT_NOW(a_data_zero, clk, rst_n, out_valid && !out_data.result_valid,
    out_data.result_data == '0)

  // fill never exceeds the pool
  `ODQ_ASSERT_NOW(a_fill_bound, clk, rst_n, out_valid,
    out_data.fill_count <= odq_pkg::FILL_W'(odq_pkg::CAPACITY))

  // input back-pressure only comes from a stalled, full output
  `ODQ_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind overwriting_bounded_deque odq_checker u_odq_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the overwriting bounded deque: a clocked driver
// feeds requests from a queue, a clocked monitor predicts every result from
// its own ring model and checks each one in order, field by field. Runs
// directed cases at 64, 0 and 2 slots, then random phases over several
// slot settings with varied idling and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [odq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  odq_pkg::odq_in_t          in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  odq_pkg::odq_out_t         out_data;
  logic                      cfg_we = 1'b0;
  logic [odq_pkg::CFG_W-1:0] cfg_wdata = '0;

  // ring model of the deque
  logic [odq_pkg::DATA_WIDTH-1:0] ring_word [odq_pkg::CAPACITY];
  int                             ring_front = 0;
  int                             ring_back = 0;
  int                             ring_fill = 0;
  logic [odq_pkg::CFG_W-1:0]      slots_setting = 7'd64;

  odq_pkg::odq_in_t  pending_reqs [$];
  odq_pkg::odq_out_t results_due [$];

  int  reqs_queued = 0;
  int  reqs_accepted = 0;
  int  results_checked = 0;
  int  fail_count = 0;
  int  evictions = 0;
  int  empty_pops = 0;
  int  settings_used = 0;
  int  quiet_cycles = 0;
  bit  req_taken = 1'b0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_armed = 1'b0;
  int  hold_done = 0;

  overwriting_bounded_deque dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void set_slots(logic [odq_pkg::CFG_W-1:0] value);
    slots_setting = value;
    ring_front = 0;
    ring_back = 0;
    ring_fill = 0;
  endfunction

  function automatic odq_pkg::odq_out_t predict_deque(odq_pkg::odq_in_t req);
    odq_pkg::odq_out_t res;
    int                slots;
    res = '0;
    // 0 behaves as one slot, anything above the pool as the full pool
    if (slots_setting == 0) slots = 1;
    else if (slots_setting > odq_pkg::CAPACITY) slots = odq_pkg::CAPACITY;
    else slots = int'(slots_setting);
    ring_front = ring_front % slots;
    ring_back = ring_back % slots;
    if (ring_fill > slots) ring_fill = slots;
    case (req.operation)
      odq_pkg::OP_PUSH_FRONT: begin
        if (ring_fill >= slots) begin
          res.result_data = ring_word[ring_front];
          res.result_valid = 1'b1;
          ring_word[ring_front] = req.push_data;
          evictions++;
        end else begin
          ring_front = (ring_front + slots - 1) % slots;
          ring_word[ring_front] = req.push_data;
          ring_fill++;
        end
      end
      odq_pkg::OP_APPEND: begin
        if (ring_fill >= slots) begin
          res.result_data = ring_word[ring_front];
          res.result_valid = 1'b1;
          ring_front = (ring_front + 1) % slots;
          evictions++;
        end else begin
          ring_fill++;
        end
        ring_word[ring_back] = req.push_data;
        ring_back = (ring_back + 1) % slots;
      end
      odq_pkg::OP_POP_FRONT: begin
        if (ring_fill > 0) begin
          res.result_data = ring_word[ring_front];
          res.result_valid = 1'b1;
          ring_front = (ring_front + 1) % slots;
          ring_fill--;
        end else begin
          empty_pops++;
        end
      end
      default: ;
    endcase
    res.fill_count = odq_pkg::FILL_W'(ring_fill);
    return res;
  endfunction

  function automatic void report_field(string name,
                                       logic [odq_pkg::DATA_WIDTH-1:0] want,
                                       logic [odq_pkg::DATA_WIDTH-1:0] got);
    fail_count++;
    $display("%0t: result %0d %s expected %h got %h", $time, results_checked, name,
             want, got);
  endfunction

  // monitor: model update on accepted requests and config writes, result check
  always @(posedge clk) begin
    odq_pkg::odq_out_t want;
    odq_pkg::odq_out_t got;
    req_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) set_slots(cfg_wdata);
      if (in_valid && !in_stall) begin
        results_due.push_back(predict_deque(in_data));
        reqs_accepted++;
        req_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none got %h", $time, got);
        end else begin
          want = results_due.pop_front();
          if (got.result_data !== want.result_data)
            report_field("result_data", want.result_data, got.result_data);
          if (got.result_valid !== want.result_valid)
            report_field("result_valid", want.result_valid, got.result_valid);
          if (got.fill_count !== want.fill_count)
            report_field("fill_count", want.fill_count, got.fill_count);
        end
        results_checked++;
      end
    end
  end

  // driver: a presented request holds until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off once armed
  always @(negedge clk) begin
    if (hold_armed && hold_done < HOLD_LEN) begin
      hold_done <= hold_done + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("overwriting_bounded_deque regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge so the driver never races the queue
  task automatic queue_req(logic [odq_pkg::OP_W-1:0] op,
                           logic [odq_pkg::DATA_WIDTH-1:0] word);
    odq_pkg::odq_in_t req;
    req.operation = op;
    req.push_data = word;
    pending_reqs.push_back(req);
    reqs_queued++;
  endtask

  function automatic logic [odq_pkg::OP_W-1:0] pick_op(int push_pct, int append_pct);
    int r;
    r = $urandom_range(99);
    if (r < 2) return OP_UNUSED;
    if (r < 2 + push_pct) return odq_pkg::OP_PUSH_FRONT;
    if (r < 2 + push_pct + append_pct) return odq_pkg::OP_APPEND;
    return odq_pkg::OP_POP_FRONT;
  endfunction

  function automatic logic [odq_pkg::DATA_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (reqs_accepted != reqs_queued || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_slots(logic [odq_pkg::CFG_W-1:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(logic [odq_pkg::CFG_W-1:0] slots, int send_pct, int recv_pct,
                            int n, int push_pct, int append_pct, bit hold);
    wait_idle();
    write_slots(slots);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    hold_armed = hold;
    for (int i = 0; i < n; i++) queue_req(pick_op(push_pct, append_pct), pick_word());
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed opener at the reset setting of 64 slots
    @(posedge clk);
    send_idle_pct = 34;
    recv_stall_pct = 68;
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);   // pop from empty
    queue_req(OP_UNUSED, 32'h1234_5678);               // unused code, empty
    queue_req(odq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    queue_req(odq_pkg::OP_APPEND, 32'hFFFF_FFFF);
    queue_req(odq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_req(OP_UNUSED, 32'hFFFF_FFFF);
    queue_req(odq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);
    queue_req(odq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);

    // zero slots behave as one: every write after the first displaces
    wait_idle();
    write_slots(7'd0);
    @(posedge clk);
    queue_req(odq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
    queue_req(odq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
    queue_req(odq_pkg::OP_APPEND, 32'h0000_0001);
    queue_req(OP_UNUSED, 32'h0000_0000);               // unused code, full
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);

    // two slots: wrap of both indices, overwrite from each end
    wait_idle();
    write_slots(7'd2);
    @(posedge clk);
    queue_req(odq_pkg::OP_APPEND, 32'h8000_0000);
    queue_req(odq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_req(odq_pkg::OP_APPEND, 32'h1234_5678);
    queue_req(odq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);
    queue_req(odq_pkg::OP_POP_FRONT, 32'h0000_0000);

    run_random(7'd1, 34, 68, 100, 40, 30, 1'b0);
    run_random(7'd3, 34, 68, 120, 35, 30, 1'b0);
    run_random(7'd127, 68, 34, 180, 45, 35, 1'b0);   // above the pool: acts as 64
    run_random(7'd0, 68, 34, 80, 35, 30, 1'b0);
    run_random(7'($urandom_range(16, 2)), 0, 0, 150, 33, 30, 1'b0);
    run_random(7'd64, 0, 0, 220, 45, 35, 1'b1);      // long output hold-off here

    wait_idle();
    repeat (20) @(negedge clk);
    if (results_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, results_due.size());
    end
    $display("Covered %0d requests over %0d slot settings (0, 1, 2, 3, 64, 127, random).",
             reqs_accepted, settings_used);
    $display("Checked %0d results: %0d evictions, %0d pops from empty, %0d failures.",
             results_checked, evictions, empty_pops, fail_count);
    if (fail_count == 0) begin
      $display("overwriting_bounded_deque regression: pass");
    end else begin
      $display("overwriting_bounded_deque regression: fail");
    end
    $finish;
  end

endmodule
